FILE: design/btt_pkg.sv
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types and constants of the bucketed transposition table: command and
// response transactions, the stored entry layout and the replacement rule.
// ----------------------------------------------------------------------------
package btt_pkg;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_SAVE   = 1'b1;

    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;
    localparam logic [1:0] BOUND_EXACT = 2'd3;

    localparam int FILL_W = 19;
    localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

    // Wide enough for the largest supported bucket (16 ways).
    localparam int WAY_IDX_W = 4;

    typedef struct packed {
        logic               func;
        logic [15:0]        key_index;
        logic [31:0]        key_check;
        logic [31:0]        move_in;
        logic signed [15:0] score_in;
        logic signed [15:0] depth_in;
        logic [1:0]         bound_in;
        logic signed [15:0] eval_in;
        logic               skip_in;
    } t_btt_in;

    typedef struct packed {
        logic               hit;
        logic [31:0]        move_out;
        logic signed [15:0] score_out;
        logic signed [15:0] depth_out;
        logic [1:0]         bound_out;
        logic signed [15:0] eval_out;
        logic               skip_out;
        logic [FILL_W-1:0]  fill_count;
    } t_btt_out;

    typedef struct packed {
        logic [31:0]        check;
        logic [31:0]        move;
        logic signed [15:0] score;
        logic signed [15:0] depth;
        logic [1:0]         bound;
        logic signed [15:0] eval;
        logic               skip;
        logic [7:0]         age;
    } t_btt_entry;

    localparam int ENTRY_W = $bits(t_btt_entry);

    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] hit_way;
        logic                 slot;
        logic [WAY_IDX_W-1:0] slot_way;
    } t_btt_probe;

    // True when way should displace the current victim candidate.
    function automatic logic btt_replace(t_btt_entry way, t_btt_entry cand,
                                         logic [7:0] age);
        logic a;
        logic b;
        logic c;
        a = (way.age == age) || (way.bound == BOUND_EXACT);
        b = (cand.age == age);
        c = (way.depth < cand.depth);
        return a ? (b && c) : (b || c);
    endfunction

endpackage

FILE: design/btt_ram.sv
// ----------------------------------------------------------------------------
// btt_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that appears in the cycle after the read.
// ----------------------------------------------------------------------------
module btt_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/btt_probe.sv
// ----------------------------------------------------------------------------
// btt_probe
// Compares the check key against every way of a bucket and finds the first
// matching way and the first way that is empty or matching.
// ----------------------------------------------------------------------------
module btt_probe import btt_pkg::*; #(
    parameter int WAYS = 4
) (
    input  t_btt_entry [WAYS-1:0] i_row,
    input  logic [31:0]           i_key,
    output t_btt_probe            o_probe
);

    logic [WAYS-1:0] w_match;
    logic [WAYS-1:0] w_free;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_match[w] = (i_row[w].check == i_key);
            w_free[w]  = w_match[w] || (i_row[w].check == 32'd0);
        end
    end

    // Scan from the top so the lowest set way wins.
    always_comb begin
        o_probe = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                o_probe.hit     = 1'b1;
                o_probe.hit_way = WAY_IDX_W'(w);
            end
            if (w_free[w]) begin
                o_probe.slot     = 1'b1;
                o_probe.slot_way = WAY_IDX_W'(w);
            end
        end
    end

endmodule

FILE: design/bucketed_transposition_table.sv
// ----------------------------------------------------------------------------
// bucketed_transposition_table
// Set-associative transposition table: lookups and saves against buckets of
// WAYS entries, held as one row per bucket in a synchronous RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  command   in         start high, busy low       i_cmd (t_btt_in)
//  response  out        o_valid, one cycle         o_rsp (t_btt_out)
//  config    in         i_cfg_we                   i_cfg_wdata (current age)
//
// A lookup, and a save into an empty or matching way (or any save when WAYS
// is 1), reads the bucket, then compares, writes back if needed and responds.
// A save into a full bucket of several ways walks them for a victim in S_SCAN.
// After reset the RAM is cleared one row per cycle with busy high;
// configuration writes are taken throughout.
// The response cannot be stalled; it appears the cycle after the compare.
// ----------------------------------------------------------------------------
module bucketed_transposition_table import btt_pkg::*; #(
    parameter int INDEX_BITS = 16,
    parameter int WAYS       = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_btt_in  i_cmd,
    input  logic     i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic     o_valid,
    output t_btt_out o_rsp
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * ENTRY_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [INDEX_BITS-1:0] r_bucket;
    t_btt_in               r_cmd;
    logic [7:0]            r_age;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [WAY_W-1:0]      r_way, n_way;
    logic [WAY_W-1:0]      r_vic, n_vic;
    logic                  r_valid, n_valid;
    t_btt_out              r_rsp, n_rsp;

    logic                    w_accept;
    logic [INDEX_BITS+15:0]  w_idx_ext;
    logic [INDEX_BITS-1:0]   w_bucket;
    logic                    w_we;
    logic [INDEX_BITS-1:0]   w_waddr;
    t_btt_entry [WAYS-1:0]   w_wdata;
    t_btt_entry [WAYS-1:0]   w_rd_row;
    t_btt_probe              w_probe;
    logic [WAY_W-1:0]        w_hit_way;
    logic [WAY_W-1:0]        w_slot_way;
    logic [WAY_W-1:0]        w_tgt;
    logic [WAY_W-1:0]        w_cand;
    logic                    w_write;
    logic                    w_merge;
    t_btt_entry              w_sel;
    t_btt_entry              w_old;
    t_btt_entry              w_new;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_idx_ext = {{INDEX_BITS{1'b0}}, i_cmd.key_index};
    assign w_bucket  = w_idx_ext[INDEX_BITS-1:0];

    btt_ram #(
        .ADDR_W (INDEX_BITS),
        .DATA_W (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_bucket),
        .o_rdata (w_rd_row)
    );

    btt_probe #(
        .WAYS (WAYS)
    ) u_probe (
        .i_row   (w_rd_row),
        .i_key   (r_cmd.key_check),
        .o_probe (w_probe)
    );

    assign w_hit_way  = w_probe.hit_way[WAY_W-1:0];
    assign w_slot_way = w_probe.slot_way[WAY_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_fill     = r_fill;
        n_way      = r_way;
        n_vic      = r_vic;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        w_we       = 1'b0;
        w_waddr    = r_bucket;
        w_wdata    = w_rd_row;
        w_tgt      = '0;
        w_cand     = r_vic;
        w_write    = 1'b0;
        w_merge    = 1'b0;
        w_sel      = w_rd_row[w_hit_way];
        w_old      = '0;
        w_new      = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {INDEX_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_cmd.func == FUNC_LOOKUP) begin
                    n_rsp            = '0;
                    n_rsp.fill_count = r_fill;
                    n_valid          = 1'b1;
                    n_state          = S_IDLE;
                    if (w_probe.hit) begin
                        n_rsp.hit       = 1'b1;
                        n_rsp.move_out  = w_sel.move;
                        n_rsp.score_out = w_sel.score;
                        n_rsp.depth_out = w_sel.depth;
                        n_rsp.bound_out = w_sel.bound;
                        n_rsp.eval_out  = w_sel.eval;
                        n_rsp.skip_out  = w_sel.skip;
                        // Refresh the age of the way that hit.
                        w_we                   = 1'b1;
                        w_wdata[w_hit_way].age = r_age;
                    end
                end else if (w_probe.slot) begin
                    w_tgt   = w_slot_way;
                    w_merge = 1'b1;
                    w_write = 1'b1;
                end else if (WAYS == 1) begin
                    w_tgt   = '0;
                    w_write = 1'b1;
                end else begin
                    n_vic   = '0;
                    n_way   = WAY_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (btt_replace(w_rd_row[r_way], w_rd_row[r_vic], r_age)) begin
                    w_cand = r_way;
                end
                n_vic = w_cand;
                n_way = r_way + 1'b1;
                if (r_way == WAY_W'(WAYS - 1)) begin
                    w_tgt   = w_cand;
                    w_write = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_write) begin
            w_old       = w_rd_row[w_tgt];
            w_new.check = r_cmd.key_check;
            w_new.move  = (w_merge && (r_cmd.move_in == 32'd0)) ? w_old.move
                                                                 : r_cmd.move_in;
            w_new.score = r_cmd.score_in;
            w_new.depth = r_cmd.depth_in;
            w_new.bound = r_cmd.bound_in;
            w_new.eval  = r_cmd.eval_in;
            w_new.skip  = (w_merge && !r_cmd.skip_in) ? w_old.skip : r_cmd.skip_in;
            w_new.age   = r_age;
            w_we           = 1'b1;
            w_wdata[w_tgt] = w_new;
            if (w_merge && (w_old.check == 32'd0) && (r_fill != FILL_MAX)) begin
                n_fill = r_fill + 1'b1;
            end
            n_rsp            = '0;
            n_rsp.fill_count = n_fill;
            n_valid          = 1'b1;
            n_state          = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_age      <= '0;
            r_fill     <= '0;
            r_way      <= '0;
            r_vic      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_fill     <= n_fill;
            r_way      <= n_way;
            r_vic      <= n_vic;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_age <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_bucket <= w_bucket;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

FILE: design/btt_checker.sv
// ----------------------------------------------------------------------------
// btt_checker
// Port-level checks of the transposition table's command/response timing
// and of the contents of responses that carry no hit.
// ----------------------------------------------------------------------------
module btt_checker import btt_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_valid,
    input t_btt_out o_rsp
);

    // One transaction gives one response, never two in a row.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("response strobe high for two cycles");

    // An accepted command occupies the block and has no response yet.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("block not busy after accepting a command");

    // A response is given as the block returns to idle.
    a_resp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("response while the block is still busy");

    // Misses and saves carry no entry contents.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.hit) |->
            (o_rsp.move_out == 32'd0) && (o_rsp.score_out == 16'sd0) &&
            (o_rsp.depth_out == 16'sd0) && (o_rsp.bound_out == BOUND_NONE) &&
            (o_rsp.eval_out == 16'sd0) && !o_rsp.skip_out)
        else $error("response without hit carries entry data");

endmodule

bind bucketed_transposition_table btt_checker u_btt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

FILE: tb/bucketed_transposition_table_test.sv
// ----------------------------------------------------------------------------
// bucketed_transposition_table_test
// Self-checking bench for the bucketed transposition table. A shadow copy of
// the buckets predicts every response; commands and age writes are queued up
// front, driven with random gaps, and responses are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bucketed_transposition_table_test;
    import btt_pkg::*;

    localparam int INDEX_BITS = 16;
    localparam int WAYS       = 4;
    localparam int IDLE_PCT   = 32;

    typedef enum logic {
        STEP_ACCESS,
        STEP_SET_AGE
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        t_btt_in    cmd;
        logic [7:0] age;
        bit         no_gaps;
    } t_tt_step;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_btt_in    i_cmd = '0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       o_valid;
    t_btt_out   o_rsp;

    t_tt_step   step_q[$];
    t_btt_out   expected_rsp_q[$];
    int         error_count = 0;

    // Shadow of the table contents; a missing key is an empty (all zero) way.
    t_btt_entry        shadow_slots[int unsigned];
    logic [7:0]        shadow_age = '0;
    logic [FILL_W-1:0] shadow_fill = '0;

    bucketed_transposition_table #(
        .INDEX_BITS(INDEX_BITS),
        .WAYS      (WAYS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_btt_entry shadow_read(int unsigned slot);
        if (shadow_slots.exists(slot)) begin
            return shadow_slots[slot];
        end
        return '0;
    endfunction

    // Applies one command to the shadow table and returns its response.
    function automatic t_btt_out predict_access(t_btt_in cmd);
        t_btt_out    rsp;
        t_btt_entry  way_e;
        t_btt_entry  cand_e;
        int unsigned base;
        int unsigned victim;
        int          w;
        int          a;
        int          b;
        int          c;
        logic [31:0] mv;
        logic        sk;

        rsp = '0;
        base = (int'(cmd.key_index) & ((1 << INDEX_BITS) - 1)) * WAYS;
        if (cmd.func == FUNC_LOOKUP) begin
            for (w = 0; w < WAYS; w++) begin
                way_e = shadow_read(base + w);
                if (way_e.check == cmd.key_check) begin
                    way_e.age = shadow_age;
                    shadow_slots[base + w] = way_e;
                    rsp.hit       = 1'b1;
                    rsp.move_out  = way_e.move;
                    rsp.score_out = way_e.score;
                    rsp.depth_out = way_e.depth;
                    rsp.bound_out = way_e.bound;
                    rsp.eval_out  = way_e.eval;
                    rsp.skip_out  = way_e.skip;
                    break;
                end
            end
        end else begin
            victim = base;
            mv = cmd.move_in;
            sk = cmd.skip_in;
            for (w = 0; w < WAYS; w++) begin
                way_e = shadow_read(base + w);
                if (way_e.check == '0 || way_e.check == cmd.key_check) begin
                    if (mv == '0) mv = way_e.move;
                    if (!sk) sk = way_e.skip;
                    if (way_e.check == '0 && shadow_fill != FILL_MAX) begin
                        shadow_fill++;
                    end
                    victim = base + w;
                    break;
                end
                // Replacement score: fresh or exact entries are worth keeping,
                // shallow ones are not.
                cand_e = shadow_read(victim);
                a = (way_e.age == shadow_age || way_e.bound == BOUND_EXACT) ? 1 : 0;
                b = (cand_e.age == shadow_age) ? 1 : 0;
                c = (way_e.depth < cand_e.depth) ? 1 : 0;
                if (a - b - c < 0) victim = base + w;
            end
            way_e.check = cmd.key_check;
            way_e.move  = mv;
            way_e.score = cmd.score_in;
            way_e.depth = cmd.depth_in;
            way_e.bound = cmd.bound_in;
            way_e.eval  = cmd.eval_in;
            way_e.skip  = sk;
            way_e.age   = shadow_age;
            shadow_slots[victim] = way_e;
        end
        rsp.fill_count = shadow_fill;
        return rsp;
    endfunction

    // Driver: one command or one age write at a time, with random gaps.
    always @(posedge i_clk) begin : drive_proc
        t_tt_step step;
        logic     next_start;
        logic     next_we;

        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (i_cfg_we) shadow_age = i_cfg_wdata;
            if (start && !busy) expected_rsp_q = {expected_rsp_q, predict_access(i_cmd)};
            next_start = start && busy;
            next_we = 1'b0;
            if (!next_start && step_q.size() != 0) begin
                step = step_q[0];
                if (step.kind == STEP_SET_AGE) begin
                    // The age only changes once every transaction has drained.
                    if (!start && !i_cfg_we && !o_valid && expected_rsp_q.size() == 0) begin
                        i_cfg_wdata <= step.age;
                        next_we = 1'b1;
                        void'(step_q.pop_front());
                    end
                end else if (step.no_gaps || $urandom_range(99) >= IDLE_PCT) begin
                    i_cmd <= step.cmd;
                    next_start = 1'b1;
                    void'(step_q.pop_front());
                end
            end
            start <= next_start;
            i_cfg_we <= next_we;
        end
    end

    task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Monitor: every response is compared with the oldest prediction.
    always @(posedge i_clk) begin : monitor_proc
        t_btt_out exp_rsp;

        if (i_rst_n && o_valid) begin
            if (expected_rsp_q.size() == 0) begin
                $display("%0t ns: unexpected response, expected none actual %0h",
                         $time, o_rsp);
                error_count++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                report_field("hit", exp_rsp.hit, o_rsp.hit);
                report_field("move_out", exp_rsp.move_out, o_rsp.move_out);
                report_field("score_out", 16'(exp_rsp.score_out), 16'(o_rsp.score_out));
                report_field("depth_out", 16'(exp_rsp.depth_out), 16'(o_rsp.depth_out));
                report_field("bound_out", exp_rsp.bound_out, o_rsp.bound_out);
                report_field("eval_out", 16'(exp_rsp.eval_out), 16'(o_rsp.eval_out));
                report_field("skip_out", exp_rsp.skip_out, o_rsp.skip_out);
                report_field("fill_count", exp_rsp.fill_count, o_rsp.fill_count);
            end
        end
    end

    function automatic t_btt_in make_access(logic f, logic [15:0] idx, logic [31:0] chk,
                                            logic [31:0] mv, logic [15:0] sc,
                                            logic [15:0] dp, logic [1:0] bd,
                                            logic [15:0] ev, logic sk);
        t_btt_in cmd;
        cmd.func      = f;
        cmd.key_index = idx;
        cmd.key_check = chk;
        cmd.move_in   = mv;
        cmd.score_in  = sc;
        cmd.depth_in  = dp;
        cmd.bound_in  = bd;
        cmd.eval_in   = ev;
        cmd.skip_in   = sk;
        return cmd;
    endfunction

    // Mostly two hot buckets and a small key pool, so that hits, refills
    // and evictions are frequent; the rest spans the full field ranges.
    function automatic t_btt_in random_access(logic [15:0] hot_a, logic [15:0] hot_b);
        t_btt_in cmd;
        int      pick;

        cmd.func = ($urandom_range(99) < 55) ? FUNC_SAVE : FUNC_LOOKUP;
        pick = $urandom_range(99);
        cmd.key_index = (pick < 45) ? hot_a : (pick < 90) ? hot_b : 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 5) cmd.key_check = '0;
        else if (pick < 88) cmd.key_check = 32'($urandom_range(1, 7));
        else if (pick < 92) cmd.key_check = '1;
        else cmd.key_check = $urandom;
        cmd.move_in  = ($urandom_range(3) == 0) ? '0 : 32'($urandom);
        cmd.score_in = 16'($urandom);
        cmd.depth_in = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 24)) - 16'd8
                                                : 16'($urandom);
        cmd.bound_in = 2'($urandom_range(3));
        cmd.eval_in  = 16'($urandom);
        cmd.skip_in  = 1'($urandom_range(1));
        return cmd;
    endfunction

    task automatic queue_access(t_btt_in cmd, bit no_gaps);
        t_tt_step step;
        step.kind = STEP_ACCESS;
        step.cmd = cmd;
        step.age = '0;
        step.no_gaps = no_gaps;
        step_q = {step_q, step};
    endtask

    task automatic queue_age(logic [7:0] age);
        t_tt_step step;
        step.kind = STEP_SET_AGE;
        step.cmd = '0;
        step.age = age;
        step.no_gaps = 1'b0;
        step_q = {step_q, step};
    endtask

    initial begin : stimulus_proc
        logic [7:0]  phase_age[5];
        logic [15:0] hot_a;
        logic [15:0] hot_b;
        int          p;
        int          n;

        phase_age[0] = 8'hFF;
        phase_age[1] = 8'h00;
        phase_age[2] = 8'($urandom);
        phase_age[3] = 8'hFF;
        phase_age[4] = 8'($urandom);

        // Directed part on the lowest and highest buckets.
        queue_age(8'd1);
        queue_access(make_access(FUNC_LOOKUP, 16'h0000, 32'd5, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);
        // A zero key matches the first empty way.
        queue_access(make_access(FUNC_LOOKUP, 16'h0000, 32'd0, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);
        // Saving a zero key leaves the way empty but still counts a fill.
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd0, 32'hDEAD_BEEF, 16'sd7,
                                 16'sd3, BOUND_LOWER, 16'sd9, 1'b1), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd1, 32'h1234_5678, 16'h8000,
                                 16'h7FFF, BOUND_EXACT, 16'h7FFF, 1'b1), 1'b0);
        // A zero move and a clear skip flag keep what is stored.
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd1, '0, 16'sd100, 16'sd5,
                                 BOUND_UPPER, 16'h8000, 1'b0), 1'b0);
        queue_access(make_access(FUNC_LOOKUP, 16'h0000, 32'd1, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd2, 32'd2, 16'sd1, 16'h8000,
                                 BOUND_NONE, 16'sd1, 1'b0), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd3, 32'd3, 16'sd2, 16'sd0,
                                 BOUND_UPPER, 16'sd2, 1'b1), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd4, 32'd4, 16'sd3, 16'sd100,
                                 BOUND_LOWER, 16'sd3, 1'b0), 1'b0);
        // Full bucket from here on: victims are picked under a new age.
        queue_age(8'd2);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd5, 32'd5, 16'sd4, 16'sd1,
                                 BOUND_EXACT, 16'sd4, 1'b0), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd6, 32'd6, 16'sd5, 16'hFFFF,
                                 BOUND_LOWER, 16'sd5, 1'b1), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'h0000, 32'd7, '0, 16'sd6, 16'sd2,
                                 BOUND_NONE, 16'sd6, 1'b0), 1'b0);
        queue_access(make_access(FUNC_LOOKUP, 16'h0000, 32'd6, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);
        queue_access(make_access(FUNC_LOOKUP, 16'h0000, 32'd5, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);
        queue_access(make_access(FUNC_SAVE, 16'hFFFF, '1, '1, '1, '1, BOUND_EXACT,
                                 '1, 1'b1), 1'b0);
        queue_access(make_access(FUNC_LOOKUP, 16'hFFFF, '1, '1, '1, '1, BOUND_EXACT,
                                 '1, 1'b1), 1'b0);
        queue_access(make_access(FUNC_LOOKUP, 16'hFFFF, 32'd0, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);
        queue_access(make_access(FUNC_LOOKUP, 16'hFFFF, 32'h0001_2345, '0, '0, '0,
                                 BOUND_NONE, '0, 1'b0), 1'b0);

        // Random phases, each opening with an age write; the middle one has no gaps.
        for (p = 0; p < 5; p++) begin
            queue_age(phase_age[p]);
            hot_a = (p == 0) ? 16'h0000 : 16'($urandom);
            hot_b = (p == 1) ? 16'hFFFF : 16'($urandom_range(0, 15));
            for (n = 0; n < 100; n++) begin
                queue_access(random_access(hot_a, hot_b), p == 2);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (step_q.size() != 0 || start || i_cfg_we || expected_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (WAYS + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // The clearing pass after reset alone covers all 2**INDEX_BITS rows.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
